// File: rtl/core/pect_pkg.sv
// shared types, constants and helpers for the polygon ear-clipping triangulator
package pect_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int TURN_W = PROD_W + 1;
  localparam int SUM_W  = TURN_W + IDX_W;
  localparam int PT_W   = 2 * COORD_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // sign of a cross product, two's complement style
  typedef enum logic [1:0] {
    SGN_ZERO = 2'b00,
    SGN_POS  = 2'b01,
    SGN_NEG  = 2'b11
  } sgn_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_NO_PROGRESS = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_START,
    S_TP_INIT, S_TP_RD, S_TP_DAT, S_TP_WAIT, S_TP_END,
    S_FAN_RD0, S_FAN_D0, S_FAN_RD, S_FAN_D,
    S_CW_RD0, S_CW_D0, S_CW_RD1, S_CW_D1, S_CW_RD, S_CW_NX,
    S_IN_RD, S_IN_D, S_IN_OP, S_IN_W,
    S_CW_KEEP, S_CW_ADV, S_CW_LAST,
    S_EMIT, S_FIN, S_ERR_FLUSH, S_ERR_PUT
  } state_e;

  typedef struct packed {
    logic valid;
    pt_t  a;
    pt_t  b;
    pt_t  c;
  } turn_req_t;

  typedef struct packed {
    logic                    valid;
    sgn_e                    sign;
    logic signed [SUM_W-1:0] value;
  } turn_rsp_t;

  typedef struct packed {
    logic [1:0] we;
    idx_t       addr;
    pt_t        data;
  } pt_wr_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    sgn_e data;
  } sgn_wr_t;

  function automatic sgn_e sign_of(input logic signed [SUM_W-1:0] z);
    sgn_e s;
    if (z < 0) s = SGN_NEG;
    else if (z != 0) s = SGN_POS;
    else s = SGN_ZERO;
    return s;
  endfunction

  function automatic logic signed [DIFF_W-1:0] ext_coord(input coord_t v);
    return {v[COORD_WIDTH-1], v};
  endfunction

endpackage

// File: rtl/core/pect_vtx_if.sv
// vertex request channel
interface pect_vtx_if import pect_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// File: rtl/core/pect_tri_if.sv
// triangle result channel
interface pect_tri_if import pect_pkg::*; ();
  logic       valid;
  logic       ready;
  coord_t     corner_a_x;
  coord_t     corner_a_y;
  coord_t     corner_b_x;
  coord_t     corner_b_y;
  coord_t     corner_c_x;
  coord_t     corner_c_y;
  logic       final_result;
  logic       no_triangle;
  logic [1:0] status;

  modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, final_result, no_triangle, status,
                  input ready);
  modport sink   (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, final_result, no_triangle, status,
                  output ready);
endinterface

// File: rtl/core/pect_ram.sv
// generic single-write, single-read memory with registered read data
module pect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pect_turn.sv
// three-stage exact cross product (turn) unit
module pect_turn import pect_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  turn_req_t req_i,
  output turn_rsp_t rsp_o
);

  logic signed [DIFF_W-1:0] dx1_q, dy1_q, dy0_q, dx2_q;
  logic signed [PROD_W-1:0] p1_q, p2_q;
  logic signed [TURN_W-1:0] z_q;
  logic [2:0]               vld_q;
  logic signed [SUM_W-1:0]  z_ext;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], req_i.valid};
    end
  end

  // differences, products, final subtract
  always_ff @(posedge clk_i) begin
    dx1_q <= ext_coord(req_i.b.x) - ext_coord(req_i.a.x);
    dy1_q <= ext_coord(req_i.c.y) - ext_coord(req_i.b.y);
    dy0_q <= ext_coord(req_i.b.y) - ext_coord(req_i.a.y);
    dx2_q <= ext_coord(req_i.c.x) - ext_coord(req_i.b.x);
    p1_q  <= dx1_q * dy1_q;
    p2_q  <= dy0_q * dx2_q;
    z_q   <= TURN_W'(p1_q) - TURN_W'(p2_q);
  end

  assign z_ext       = SUM_W'(z_q);
  assign rsp_o.valid = vld_q[2];
  assign rsp_o.value = z_ext;
  assign rsp_o.sign  = sign_of(z_ext);

endmodule

// File: rtl/core/pect_seq.sv
// sequencer: vertex loading, turn passes, fan split, ear clipping and result queue
module pect_seq import pect_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pect_vtx_if.sink  vtx_i,
  pect_tri_if.source tri_o,
  output turn_req_t turn_req_o,
  input  turn_rsp_t turn_rsp_i,
  output pt_wr_t    pt_wr_o,
  output idx_t      pt_raddr_o,
  input  pt_t       bank0_rdata_i,
  input  pt_t       bank1_rdata_i,
  output sgn_wr_t   sgn_wr_o,
  output idx_t      sgn_raddr_o,
  input  sgn_e      sgn_rdata_i
);

  state_e state_q, state_d, ret_q, ret_d;
  cnt_t   cnt_q, cnt_d, n_q, n_d, i_q, i_d, nxt_q, nxt_d, m_q, m_d;
  logic   ovf_q, ovf_d, bank_q, bank_d;
  logic [1:0] k_q, k_d;
  pt_t    pa_q, pa_d, pb_q, pb_d, f_q, f_d, q1_q, q1_d, q2_q, q2_d, pt_q, pt_d;
  pt_t    ta_q, ta_d, tb_q, tb_d, tc_q, tc_d;
  pt_t    pend_a_q, pend_a_d, pend_b_q, pend_b_d, pend_c_q, pend_c_d;
  pt_t    out_a_q, out_a_d, out_b_q, out_b_d, out_c_q, out_c_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic   seen_pos_q, seen_pos_d, seen_neg_q, seen_neg_d, seen_zero_q, seen_zero_d;
  sgn_e   all_q, all_d, d_q, d_d, s0_q, s0_d, s1_q, s1_d;
  status_e status_q, status_d, out_status_q, out_status_d;
  logic   pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic   out_final_q, out_final_d, out_none_q, out_none_d;

  logic   vtx_acc, out_free, convex_c, inside_c, last_scan, cw_end;
  pt_t    cur;
  sgn_e   all_c;
  cnt_t   i_m2, nxt_p1, nxt_m1, m_p1;

  assign vtx_acc   = vtx_i.valid && vtx_i.ready;
  assign out_free  = !out_v_q || tri_o.ready;
  assign cur       = bank_q ? bank1_rdata_i : bank0_rdata_i;
  assign all_c     = sign_of(sum_q);
  assign inside_c  = (s0_q == s1_q) && (s1_q == turn_rsp_i.sign);
  assign last_scan = (i_q + cnt_t'(1)) == n_q;
  assign i_m2      = i_q - cnt_t'(2);
  assign nxt_p1    = nxt_q + cnt_t'(1);
  assign nxt_m1    = nxt_q - cnt_t'(1);
  assign m_p1      = m_q + cnt_t'(1);
  assign cw_end    = nxt_p1 == (n_q - cnt_t'(1));

  // every inner turn agrees with the sign of the sum
  always_comb begin
    case (all_c)
      SGN_POS:  convex_c = !seen_neg_q && !seen_zero_q;
      SGN_NEG:  convex_c = !seen_pos_q && !seen_zero_q;
      SGN_ZERO: convex_c = !seen_pos_q && !seen_neg_q;
      default:  convex_c = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (vtx_acc && vtx_i.last_vertex) state_d = S_START;
      S_START: begin
        if (ovf_q) state_d = S_ERR_FLUSH;
        else if (cnt_q <= cnt_t'(2)) state_d = S_FIN;
        else state_d = S_TP_INIT;
      end
      S_TP_INIT:   state_d = S_TP_RD;
      S_TP_RD:     state_d = S_TP_DAT;
      S_TP_DAT:    state_d = (i_q >= cnt_t'(2)) ? S_TP_WAIT : S_TP_RD;
      S_TP_WAIT:   if (turn_rsp_i.valid) state_d = last_scan ? S_TP_END : S_TP_RD;
      S_TP_END:    state_d = convex_c ? S_FAN_RD0 : S_CW_RD0;
      S_FAN_RD0:   state_d = S_FAN_D0;
      S_FAN_D0:    state_d = S_FAN_RD;
      S_FAN_RD:    state_d = S_FAN_D;
      S_FAN_D:     state_d = (i_q < cnt_t'(2)) ? S_FAN_RD : S_EMIT;
      S_CW_RD0:    state_d = S_CW_D0;
      S_CW_D0:     state_d = S_CW_RD1;
      S_CW_RD1:    state_d = S_CW_D1;
      S_CW_D1:     state_d = S_CW_RD;
      S_CW_RD:     state_d = S_CW_NX;
      S_CW_NX:     state_d = (sgn_rdata_i == all_q) ? S_IN_RD : S_CW_KEEP;
      S_IN_RD:     state_d = S_IN_D;
      S_IN_D:      state_d = S_IN_OP;
      S_IN_OP:     state_d = S_IN_W;
      S_IN_W: begin
        if (turn_rsp_i.valid) begin
          if (k_q == 2'd2) begin
            if (inside_c) state_d = S_CW_KEEP;
            else if (last_scan) state_d = S_EMIT;
            else state_d = S_IN_RD;
          end else begin
            state_d = S_IN_OP;
          end
        end
      end
      S_CW_KEEP:   state_d = S_CW_ADV;
      S_CW_ADV:    state_d = cw_end ? S_CW_LAST : S_CW_RD;
      S_CW_LAST: begin
        if (m_p1 >= n_q) state_d = S_ERR_FLUSH;
        else if (m_p1 > cnt_t'(2)) state_d = S_TP_INIT;
        else state_d = S_FIN;
      end
      S_EMIT:      if (!pend_v_q || out_free) state_d = ret_q;
      S_FIN:       if (out_free) state_d = S_IDLE;
      S_ERR_FLUSH: if (!pend_v_q || out_free) state_d = S_ERR_PUT;
      S_ERR_PUT:   if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and memory port control
  always_comb begin
    ret_d = ret_q;  cnt_d = cnt_q;  n_d = n_q;  i_d = i_q;  nxt_d = nxt_q;  m_d = m_q;
    ovf_d = ovf_q;  bank_d = bank_q;  k_d = k_q;
    pa_d = pa_q;  pb_d = pb_q;  f_d = f_q;  q1_d = q1_q;  q2_d = q2_q;  pt_d = pt_q;
    ta_d = ta_q;  tb_d = tb_q;  tc_d = tc_q;
    pend_a_d = pend_a_q;  pend_b_d = pend_b_q;  pend_c_d = pend_c_q;  pend_v_d = pend_v_q;
    sum_d = sum_q;  seen_pos_d = seen_pos_q;  seen_neg_d = seen_neg_q;
    seen_zero_d = seen_zero_q;
    all_d = all_q;  d_d = d_q;  s0_d = s0_q;  s1_d = s1_q;  status_d = status_q;
    out_v_d = out_v_q && !tri_o.ready;
    out_a_d = out_a_q;  out_b_d = out_b_q;  out_c_d = out_c_q;
    out_final_d = out_final_q;  out_none_d = out_none_q;  out_status_d = out_status_q;

    turn_req_o  = '0;
    pt_wr_o     = '0;
    pt_raddr_o  = '0;
    sgn_wr_o    = '0;
    sgn_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (vtx_acc) begin
          if (cnt_q < cnt_t'(MAX_VERTICES)) begin
            pt_wr_o.we     = 2'b01;
            pt_wr_o.addr   = cnt_q[IDX_W-1:0];
            pt_wr_o.data.x = vtx_i.vertex_x;
            pt_wr_o.data.y = vtx_i.vertex_y;
            cnt_d          = cnt_q + cnt_t'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      S_START: begin
        n_d      = cnt_q;
        cnt_d    = '0;
        ovf_d    = 1'b0;
        bank_d   = 1'b0;
        status_d = ST_OVERFLOW;
      end
      // turn pass over the current points
      S_TP_INIT: begin
        i_d         = '0;
        sum_d       = '0;
        seen_pos_d  = 1'b0;
        seen_neg_d  = 1'b0;
        seen_zero_d = 1'b0;
      end
      S_TP_RD: pt_raddr_o = i_q[IDX_W-1:0];
      S_TP_DAT: begin
        pa_d = pb_q;
        pb_d = cur;
        if (i_q >= cnt_t'(2)) begin
          turn_req_o.valid = 1'b1;
          turn_req_o.a     = pa_q;
          turn_req_o.b     = pb_q;
          turn_req_o.c     = cur;
        end else begin
          i_d = i_q + cnt_t'(1);
        end
      end
      S_TP_WAIT: begin
        if (turn_rsp_i.valid) begin
          sgn_wr_o.we   = 1'b1;
          sgn_wr_o.addr = i_m2[IDX_W-1:0];
          sgn_wr_o.data = turn_rsp_i.sign;
          sum_d         = sum_q + turn_rsp_i.value;
          if (turn_rsp_i.sign == SGN_POS) seen_pos_d = 1'b1;
          if (turn_rsp_i.sign == SGN_NEG) seen_neg_d = 1'b1;
          if (turn_rsp_i.sign == SGN_ZERO) seen_zero_d = 1'b1;
          i_d = i_q + cnt_t'(1);
        end
      end
      S_TP_END: all_d = all_c;
      // fan split from the first point
      S_FAN_RD0: pt_raddr_o = '0;
      S_FAN_D0: begin
        pa_d = cur;
        i_d  = cnt_t'(1);
      end
      S_FAN_RD: pt_raddr_o = i_q[IDX_W-1:0];
      S_FAN_D: begin
        pb_d = cur;
        i_d  = i_q + cnt_t'(1);
        if (i_q >= cnt_t'(2)) begin
          ta_d  = pa_q;
          tb_d  = pb_q;
          tc_d  = cur;
          ret_d = last_scan ? S_FIN : S_FAN_RD;
        end
      end
      // clip walk, kept points go to the other bank
      S_CW_RD0: pt_raddr_o = '0;
      S_CW_D0: begin
        f_d          = cur;
        pt_wr_o.we   = bank_q ? 2'b01 : 2'b10;
        pt_wr_o.addr = '0;
        pt_wr_o.data = cur;
        m_d          = cnt_t'(1);
        nxt_d        = cnt_t'(1);
      end
      S_CW_RD1: pt_raddr_o = idx_t'(1);
      S_CW_D1:  q1_d = cur;
      S_CW_RD: begin
        pt_raddr_o  = nxt_p1[IDX_W-1:0];
        sgn_raddr_o = nxt_m1[IDX_W-1:0];
      end
      S_CW_NX: begin
        q2_d = cur;
        d_d  = sgn_rdata_i;
        i_d  = '0;
      end
      // containment scan over all points
      S_IN_RD: pt_raddr_o = i_q[IDX_W-1:0];
      S_IN_D: begin
        pt_d = cur;
        k_d  = 2'd0;
      end
      S_IN_OP: begin
        turn_req_o.valid = 1'b1;
        turn_req_o.c     = pt_q;
        case (k_q)
          2'd0: begin
            turn_req_o.a = q1_q;
            turn_req_o.b = q2_q;
          end
          2'd1: begin
            turn_req_o.a = f_q;
            turn_req_o.b = q1_q;
          end
          default: begin
            turn_req_o.a = q2_q;
            turn_req_o.b = f_q;
          end
        endcase
      end
      S_IN_W: begin
        if (turn_rsp_i.valid) begin
          k_d = k_q + 2'd1;
          if (k_q == 2'd0) s0_d = turn_rsp_i.sign;
          if (k_q == 2'd1) s1_d = turn_rsp_i.sign;
          if (k_q == 2'd2 && !inside_c) begin
            i_d = i_q + cnt_t'(1);
            if (last_scan) begin
              ta_d  = f_q;
              tb_d  = q1_q;
              tc_d  = q2_q;
              ret_d = S_CW_ADV;
            end
          end
        end
      end
      S_CW_KEEP: begin
        if (d_q != SGN_ZERO) begin
          pt_wr_o.we   = bank_q ? 2'b01 : 2'b10;
          pt_wr_o.addr = m_q[IDX_W-1:0];
          pt_wr_o.data = q1_q;
          m_d          = m_p1;
          f_d          = q1_q;
        end
      end
      S_CW_ADV: begin
        q1_d  = q2_q;
        nxt_d = nxt_p1;
      end
      S_CW_LAST: begin
        pt_wr_o.we   = bank_q ? 2'b01 : 2'b10;
        pt_wr_o.addr = m_q[IDX_W-1:0];
        pt_wr_o.data = q1_q;
        if (m_p1 >= n_q) begin
          status_d = ST_NO_PROGRESS;
        end else begin
          n_d    = m_p1;
          bank_d = !bank_q;
        end
      end
      // triangle into the holding slot, older one to the output register
      S_EMIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d      = 1'b1;
            out_a_d      = pend_a_q;
            out_b_d      = pend_b_q;
            out_c_d      = pend_c_q;
            out_final_d  = 1'b0;
            out_none_d   = 1'b0;
            out_status_d = ST_OK;
          end
          pend_a_d = ta_q;
          pend_b_d = tb_q;
          pend_c_d = tc_q;
          pend_v_d = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_v_d      = 1'b1;
          out_final_d  = 1'b1;
          out_none_d   = !pend_v_q;
          out_status_d = ST_OK;
          out_a_d      = pend_v_q ? pend_a_q : '0;
          out_b_d      = pend_v_q ? pend_b_q : '0;
          out_c_d      = pend_v_q ? pend_c_q : '0;
          pend_v_d     = 1'b0;
        end
      end
      S_ERR_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_v_d      = 1'b1;
          out_a_d      = pend_a_q;
          out_b_d      = pend_b_q;
          out_c_d      = pend_c_q;
          out_final_d  = 1'b0;
          out_none_d   = 1'b0;
          out_status_d = ST_OK;
          pend_v_d     = 1'b0;
        end
      end
      S_ERR_PUT: begin
        if (out_free) begin
          out_v_d      = 1'b1;
          out_a_d      = '0;
          out_b_d      = '0;
          out_c_d      = '0;
          out_final_d  = 1'b1;
          out_none_d   = 1'b1;
          out_status_d = status_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;  n_q <= n_d;  i_q <= i_d;  nxt_q <= nxt_d;  m_q <= m_d;
    bank_q <= bank_d;  k_q <= k_d;
    pa_q <= pa_d;  pb_q <= pb_d;  f_q <= f_d;  q1_q <= q1_d;  q2_q <= q2_d;  pt_q <= pt_d;
    ta_q <= ta_d;  tb_q <= tb_d;  tc_q <= tc_d;
    pend_a_q <= pend_a_d;  pend_b_q <= pend_b_d;  pend_c_q <= pend_c_d;
    sum_q <= sum_d;  seen_pos_q <= seen_pos_d;  seen_neg_q <= seen_neg_d;
    seen_zero_q <= seen_zero_d;
    all_q <= all_d;  d_q <= d_d;  s0_q <= s0_d;  s1_q <= s1_d;  status_q <= status_d;
    out_a_q <= out_a_d;  out_b_q <= out_b_d;  out_c_q <= out_c_d;
    out_final_q <= out_final_d;  out_none_q <= out_none_d;  out_status_q <= out_status_d;
  end

  // channel outputs
  assign vtx_i.ready        = (state_q == S_IDLE);
  assign tri_o.valid        = out_v_q;
  assign tri_o.corner_a_x   = out_a_q.x;
  assign tri_o.corner_a_y   = out_a_q.y;
  assign tri_o.corner_b_x   = out_b_q.x;
  assign tri_o.corner_b_y   = out_b_q.y;
  assign tri_o.corner_c_x   = out_c_q.x;
  assign tri_o.corner_c_y   = out_c_q.y;
  assign tri_o.final_result = out_final_q;
  assign tri_o.no_triangle  = out_none_q;
  assign tri_o.status       = out_status_q;

endmodule

// File: rtl/core/polygon_ear_clipping_triangulator_top.sv
// top level of the polygon ear-clipping triangulator
//
//  channel | direction | payload                                   | request
//  vtx_i   | in        | vertex_x, vertex_y, last_vertex            | one vertex
//  tri_o   | out       | corners a/b/c, final_result, no_triangle,  | one triangle
//          |           | status                                     | or status
//
// a vertex without the last mark leaves the input open; the last one starts triangulation
// each pass reads the point bank once, feeding each new point through the turn unit,
// then each ear candidate scans the points with three turns each until one lies inside
// the single read port of the point banks and the turn unit pipeline set the pace of both
// reset clears the sequencer and the turn unit valid pipeline; the memories need no clearing pass
// a full output register stalls the sequencer when a second triangle is ready or a final result is due
module polygon_ear_clipping_triangulator_top import pect_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pect_vtx_if.sink   vtx_i,
  pect_tri_if.source tri_o
);

  turn_req_t        turn_req;
  turn_rsp_t        turn_rsp;
  pt_wr_t           pt_wr;
  idx_t             pt_raddr;
  logic [PT_W-1:0]  bank0_rdata, bank1_rdata;
  sgn_wr_t          sgn_wr;
  idx_t             sgn_raddr;
  logic [1:0]       sgn_rdata;

  // sequencer
  pect_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vtx_i         (vtx_i),
    .tri_o         (tri_o),
    .turn_req_o    (turn_req),
    .turn_rsp_i    (turn_rsp),
    .pt_wr_o       (pt_wr),
    .pt_raddr_o    (pt_raddr),
    .bank0_rdata_i (pt_t'(bank0_rdata)),
    .bank1_rdata_i (pt_t'(bank1_rdata)),
    .sgn_wr_o      (sgn_wr),
    .sgn_raddr_o   (sgn_raddr),
    .sgn_rdata_i   (sgn_e'(sgn_rdata))
  );

  // cross product unit
  pect_turn u_turn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (turn_req),
    .rsp_o  (turn_rsp)
  );

  // ping-pong point banks
  pect_ram #(.WIDTH(PT_W), .DEPTH(MAX_VERTICES)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (pt_wr.we[0]),
    .waddr_i (pt_wr.addr),
    .wdata_i (pt_wr.data),
    .raddr_i (pt_raddr),
    .rdata_o (bank0_rdata)
  );

  pect_ram #(.WIDTH(PT_W), .DEPTH(MAX_VERTICES)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (pt_wr.we[1]),
    .waddr_i (pt_wr.addr),
    .wdata_i (pt_wr.data),
    .raddr_i (pt_raddr),
    .rdata_o (bank1_rdata)
  );

  // turn sign store
  pect_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_sgn (
    .clk_i   (clk_i),
    .we_i    (sgn_wr.we),
    .waddr_i (sgn_wr.addr),
    .wdata_i (sgn_wr.data),
    .raddr_i (sgn_raddr),
    .rdata_o (sgn_rdata)
  );

endmodule

// File: rtl/core/pect_checker.sv
// port-level checks for the triangulator top, attached by bind
module pect_checker import pect_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       vtx_valid_i,
  input logic       vtx_ready_i,
  input logic       vtx_last_i,
  input logic       tri_valid_i,
  input logic       tri_ready_i,
  input logic       tri_final_i,
  input logic       tri_none_i,
  input logic [1:0] tri_status_i,
  input coord_t     tri_corner_a_x_i
);

  // a result without a triangle always closes the polygon
  a_none_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && tri_none_i |-> tri_final_i)
    else $error("no_triangle result not marked final");

  // triangle results report ok status
  a_tri_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && !tri_none_i |-> tri_status_i == ST_OK)
    else $error("triangle result with error status");

  // the last vertex closes the input until triangulation is done
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_i && vtx_ready_i && vtx_last_i |=> !vtx_ready_i)
    else $error("vertex request taken right after last vertex");

  // a non-final result means the polygon is still in work
  a_mid_polygon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && !tri_final_i |-> !vtx_ready_i)
    else $error("vertex input open while polygon results pending");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && !tri_ready_i |=> tri_valid_i && $stable(tri_final_i)
      && $stable(tri_none_i) && $stable(tri_corner_a_x_i))
    else $error("stalled result changed");

endmodule

bind polygon_ear_clipping_triangulator_top pect_checker u_pect_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .vtx_valid_i      (vtx_i.valid),
  .vtx_ready_i      (vtx_i.ready),
  .vtx_last_i       (vtx_i.last_vertex),
  .tri_valid_i      (tri_o.valid),
  .tri_ready_i      (tri_o.ready),
  .tri_final_i      (tri_o.final_result),
  .tri_none_i       (tri_o.no_triangle),
  .tri_status_i     (tri_o.status),
  .tri_corner_a_x_i (tri_o.corner_a_x)
);

// File: tb/tb_polygon_ear_clipping_triangulator_top.sv
// testbench for the polygon ear-clipping triangulator top level
`timescale 1ns / 1ps

module tb_polygon_ear_clipping_triangulator_top;
  import pect_pkg::*;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int MAX_TRIS       = MAX_VERTICES - 2;

  typedef struct {
    coord_t     ax, ay, bx, by, cx, cy;
    logic       last_tri;
    logic       empty;
    logic [1:0] status;
  } tri_t;

  logic clk_i;
  logic rst_ni;

  pect_vtx_if vtx ();
  pect_tri_if res ();

  polygon_ear_clipping_triangulator_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx.sink),
    .tri_o  (res.source)
  );

  // shadow copy of the block state
  longint pts_x [MAX_VERTICES];
  longint pts_y [MAX_VERTICES];
  int     pts_cnt;
  bit     pts_overflow;

  tri_t   expected_tris [$];
  int     errors;
  int     vertices_sent;
  int     polygons_sent;
  int     tris_checked;
  int     overflow_seen_cnt;
  int     stall_seen_cnt;
  int     idle_cnt;
  int     snd_idle_pct;
  int     rcv_idle_pct;
  int     rcv_hold_cycles;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic longint cross_turn(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy);
    return (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
  endfunction

  function automatic int sign_val(longint z);
    return (z < 0) ? -1 : ((z > 0) ? 1 : 0);
  endfunction

  // push one result, capped at the most triangles a polygon can give
  function automatic void push_tri(ref int k, input longint a [6], input bit empty,
                                   input logic [1:0] st);
    tri_t t;
    if (k >= MAX_TRIS) return;
    t.ax = coord_t'(a[0]); t.ay = coord_t'(a[1]);
    t.bx = coord_t'(a[2]); t.by = coord_t'(a[3]);
    t.cx = coord_t'(a[4]); t.cy = coord_t'(a[5]);
    t.last_tri = 1'b0;
    t.empty = empty;
    t.status = st;
    expected_tris.insert(expected_tris.size(), t);
    k++;
  endfunction

  function automatic void push_corners(ref int k, input int a, input int b, input int c);
    longint v [6];
    v[0] = pts_x[a]; v[1] = pts_y[a];
    v[2] = pts_x[b]; v[3] = pts_y[b];
    v[4] = pts_x[c]; v[5] = pts_y[c];
    push_tri(k, v, 1'b0, ST_OK);
  endfunction

  // point strictly inside triangle a,b,c of the stored points
  function automatic bit point_inside(longint px, longint py, int a, int b, int c);
    int s1, s2, s3;
    s2 = sign_val(cross_turn(pts_x[b], pts_y[b], pts_x[c], pts_y[c], px, py));
    s1 = sign_val(cross_turn(pts_x[a], pts_y[a], pts_x[b], pts_y[b], px, py));
    s3 = sign_val(cross_turn(pts_x[c], pts_y[c], pts_x[a], pts_y[a], px, py));
    return (s1 == s2) && (s2 == s3);
  endfunction

  // predicts the triangles caused by one vertex request
  function automatic void triangulate_vertex(coord_t x, coord_t y, logic last);
    longint zero6 [6];
    longint keep_x [MAX_VERTICES];
    longint keep_y [MAX_VERTICES];
    int     turn_sgn [MAX_VERTICES];
    int     n, k, m, first, all_sgn;
    longint sum, z;
    bit     convex, covered;
    tri_t   t;
    foreach (zero6[j]) zero6[j] = 0;
    k = 0;
    if (pts_cnt < MAX_VERTICES) begin
      pts_x[pts_cnt] = x;
      pts_y[pts_cnt] = y;
      pts_cnt++;
    end else begin
      pts_overflow = 1'b1;
    end
    if (!last) return;
    n = pts_cnt;
    if (pts_overflow) begin
      push_tri(k, zero6, 1'b1, ST_OVERFLOW);
      overflow_seen_cnt++;
      n = 0;
    end
    while (n > 2) begin
      sum = 0;
      for (int i = 2; i < n; i++) begin
        z = cross_turn(pts_x[i-2], pts_y[i-2], pts_x[i-1], pts_y[i-1], pts_x[i], pts_y[i]);
        turn_sgn[i-2] = sign_val(z);
        sum += z;
      end
      all_sgn = sign_val(sum);
      convex = 1'b1;
      for (int i = 0; i < n - 2; i++)
        if (turn_sgn[i] != all_sgn) convex = 1'b0;
      if (convex) begin
        for (int i = 2; i < n; i++) push_corners(k, 0, i - 1, i);
        break;
      end
      // clip pass
      m = 0;
      keep_x[0] = pts_x[0];
      keep_y[0] = pts_y[0];
      m = 1;
      first = 0;
      for (int nx = 1; nx < n - 1; nx++) begin
        covered = 1'b0;
        if (turn_sgn[nx-1] == all_sgn)
          for (int i = 0; i < n; i++)
            if (point_inside(pts_x[i], pts_y[i], first, nx, nx + 1)) covered = 1'b1;
        if (turn_sgn[nx-1] == all_sgn && !covered) begin
          push_corners(k, first, nx, nx + 1);
        end else if (turn_sgn[nx-1] != 0) begin
          keep_x[m] = pts_x[nx];
          keep_y[m] = pts_y[nx];
          m++;
          first = nx;
        end
      end
      keep_x[m] = pts_x[n-1];
      keep_y[m] = pts_y[n-1];
      m++;
      if (m >= n) begin
        push_tri(k, zero6, 1'b1, ST_NO_PROGRESS);
        stall_seen_cnt++;
        break;
      end
      for (int i = 0; i < m; i++) begin
        pts_x[i] = keep_x[i];
        pts_y[i] = keep_y[i];
      end
      n = m;
    end
    if (k == 0) push_tri(k, zero6, 1'b1, ST_OK);
    t = expected_tris[$];
    t.last_tri = 1'b1;
    expected_tris[expected_tris.size() - 1] = t;
    pts_cnt = 0;
    pts_overflow = 1'b0;
  endfunction

  // sends one vertex request and waits for it to be taken
  task automatic send_vertex(int x, int y, bit last);
    while ($urandom_range(99) < snd_idle_pct) begin
      vtx.valid = 1'b0;
      @(negedge clk_i);
    end
    vtx.valid       = 1'b1;
    vtx.vertex_x    = coord_t'(x);
    vtx.vertex_y    = coord_t'(y);
    vtx.last_vertex = last;
    do @(posedge clk_i); while (!vtx.ready);
    triangulate_vertex(coord_t'(x), coord_t'(y), last);
    vertices_sent++;
    if (last) polygons_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_polygon(int xs [$], int ys [$]);
    foreach (xs[i]) send_vertex(xs[i], ys[i], i == xs.size() - 1);
  endtask

  // waits until every expected triangle has come out
  task automatic drain();
    vtx.valid = 1'b0;
    while (expected_tris.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // result receiver
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rcv_hold_cycles > 0) begin
        res.ready = 1'b0;
        rcv_hold_cycles--;
      end else begin
        res.ready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tri_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_tris.size() == 0) begin
        $display("%0t: unexpected triangle a=(%0d,%0d) status=%0d", $time,
                 res.corner_a_x, res.corner_a_y, res.status);
        errors++;
      end else begin
        e = expected_tris.pop_front();
        tris_checked++;
        if ({res.corner_a_x, res.corner_a_y, res.corner_b_x, res.corner_b_y,
             res.corner_c_x, res.corner_c_y, res.final_result, res.no_triangle,
             res.status} !== {e.ax, e.ay, e.bx, e.by, e.cx, e.cy, e.last_tri,
             e.empty, e.status}) begin
          $display({"%0t: mismatch expected a=(%0d,%0d) b=(%0d,%0d) c=(%0d,%0d)",
                    " fin=%0b none=%0b st=%0d"},
                   $time, e.ax, e.ay, e.bx, e.by, e.cx, e.cy, e.last_tri, e.empty,
                   e.status);
          $display({"%0t:          actual   a=(%0d,%0d) b=(%0d,%0d) c=(%0d,%0d)",
                    " fin=%0b none=%0b st=%0d"},
                   $time, res.corner_a_x, res.corner_a_y, res.corner_b_x, res.corner_b_y,
                   res.corner_c_x, res.corner_c_y, res.final_result, res.no_triangle,
                   res.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("polygon_ear_clipping_triangulator_top test failed");
      $finish;
    end
  end

  // small shapes: triangles both ways, short polygons, collinear, concave, extremes
  task automatic test_basic_shapes();
    send_polygon('{0, 10, 0}, '{0, 0, 10});
    send_polygon('{0, 0, 10}, '{0, 10, 0});
    send_polygon('{5}, '{-5});
    send_polygon('{1, 2}, '{3, 4});
    send_polygon('{0, 1, 2, 3}, '{0, 1, 2, 3});
    send_polygon('{0, 4, 2, 4, 0}, '{0, 0, 1, 4, 4});
    send_polygon('{-32768, 32767, 32767, -32768}, '{-32768, -32768, 32767, 32767});
  endtask

  // crossed shapes whose ears all hold a point, aimed at the stuck pass
  task automatic test_stuck_shapes();
    send_polygon('{0, 10, 0, 10, 5}, '{0, 10, 10, 0, 5});
    send_polygon('{0, 6, 3, 3, 3}, '{0, 0, 6, 1, 2});
  endtask

  // more vertices than the store holds
  task automatic test_overflow();
    for (int i = 0; i <= MAX_VERTICES; i++)
      send_vertex($urandom_range(65535), $urandom_range(65535), i == MAX_VERTICES);
  endtask

  // largest convex polygon on a parabola, one fan of triangles
  task automatic test_full_convex();
    for (int i = 0; i < MAX_VERTICES; i++)
      send_vertex(i * 100 - 3200, i * i - 2000, i == MAX_VERTICES - 1);
  endtask

  // output stalled long enough for the block to back up into its input
  task automatic test_output_hold();
    rcv_hold_cycles = 3000;
    for (int p = 0; p < 4; p++)
      send_polygon('{0, 8, 8, 4, 0}, '{0, 0, 8, 3, 8});
  endtask

  task automatic send_random_polygon();
    int n, range, r;
    r = $urandom_range(99);
    n = (r < 5) ? $urandom_range(1, 2) : $urandom_range(3, 12);
    range = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      if (range == 0)
        send_vertex($urandom_range(7), $urandom_range(7), i == n - 1);
      else if (range == 1)
        send_vertex($urandom_range(200) - 100, $urandom_range(200) - 100, i == n - 1);
      else
        send_vertex($urandom_range(65535), $urandom_range(65535), i == n - 1);
    end
  endtask

  task automatic test_random(int sender_idle, int receiver_idle, int n_items);
    int start;
    snd_idle_pct = sender_idle;
    rcv_idle_pct = receiver_idle;
    start = vertices_sent;
    while (vertices_sent - start < n_items) send_random_polygon();
    drain();
  endtask

  initial begin
    errors = 0; vertices_sent = 0; polygons_sent = 0; tris_checked = 0;
    overflow_seen_cnt = 0; stall_seen_cnt = 0; idle_cnt = 0;
    pts_cnt = 0; pts_overflow = 1'b0; rcv_hold_cycles = 0;
    snd_idle_pct = 19; rcv_idle_pct = 53;
    vtx.valid = 1'b0; vtx.vertex_x = '0; vtx.vertex_y = '0; vtx.last_vertex = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_shapes();
    test_stuck_shapes();
    drain();
    test_overflow();
    test_full_convex();
    drain();
    test_output_hold();
    drain();
    test_random(19, 53, 96);
    test_random(53, 19, 96);
    test_random(0, 0, 96);

    $display("run covered %0d vertices in %0d polygons, %0d results checked",
             vertices_sent, polygons_sent, tris_checked);
    $display("overflow cases %0d, stuck passes %0d", overflow_seen_cnt, stall_seen_cnt);
    if (errors == 0) begin
      $display("polygon_ear_clipping_triangulator_top test passed");
    end else begin
      $display("polygon_ear_clipping_triangulator_top test failed");
    end
    $finish;
  end

endmodule
